// ===== src/nscr_pkg.sv =====
package nscr_pkg;

  localparam int unsigned SOURCE_PIXELS_DEF = 65536;
  localparam int unsigned COORD_BITS_DEF    = 12;

  // configuration register indexes (byte address 4*index)
  localparam logic [2:0] REG_SRC_W  = 3'd0;
  localparam logic [2:0] REG_SRC_H  = 3'd1;
  localparam logic [2:0] REG_TGT_W  = 3'd2;
  localparam logic [2:0] REG_TGT_H  = 3'd3;
  localparam logic [2:0] REG_CROP   = 3'd4;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned SRC_W      = 9;
  localparam int unsigned MUL_W      = 11;
  localparam int unsigned OFF_W      = 10;
  localparam int unsigned DEN_W      = 15;
  localparam int unsigned REM_W      = 24;
  localparam int unsigned DIV_STAGES = 9;
  localparam int unsigned LANE_LAT   = DIV_STAGES + 2;

  typedef logic [15:0] half_lut_t [256];

  // half code of b/255: round to single first, then round half up to 10 bits
  function automatic half_lut_t build_half_lut();
    half_lut_t lut;
    longint unsigned b, k, num, q, r, mant, hexp;
    int i, j;
    for (i = 0; i < 256; i++) begin
      b = longint'(i);
      if (b == 0) begin
        lut[i] = 16'h0000;
      end else begin
        k = 0;
        for (j = 0; j < 8; j++) begin
          if ((b << k) < 255) k = k + 1;
        end
        num = b << (23 + k);
        q = num / 255;
        r = num % 255;
        if (2 * r > 255) q = q + 1;
        if (q >= 64'h1000000) begin
          q = q >> 1;
          if (k > 0) k = k - 1;
        end
        mant = q & 64'h7fffff;
        hexp = 15 - k;
        lut[i] = 16'(((hexp << 10) + ((mant + 64'h1000) >> 13)) & 64'hffff);
      end
    end
    return lut;
  endfunction

  localparam half_lut_t HALF_LUT = build_half_lut();

endpackage

// ===== src/nearest_scale_crop_rgba8_to_half.sv =====
// Channel  | Dir | Handshake                | Contents
// in_      | in  | tvalid/tready            | tuser op, tdata load fields + target coord
// out_     | out | tvalid/tready            | tuser out_of_range, tdata four half codes
// cfg_     | in  | APB psel/penable, pready | five registers at byte address 4*index
//
// One item per clock when the output is drained. Each item passes through
// the two 9-stage quotient dividers running side by side for x and y, then
// the address multiply and the store read, into the output buffer.
// Synchronous active-low reset clears valid bits, the output buffer and the
// registers; the source store is not cleared. A stalled output fills a
// two-entry buffer, then the whole pipeline holds and in_tready drops.
module nearest_scale_crop_rgba8_to_half #(
  parameter int unsigned SOURCE_PIXELS = nscr_pkg::SOURCE_PIXELS_DEF,
  parameter int unsigned COORD_BITS    = nscr_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] pixel_addr, [23:16] red_in, [31:24] green_in, [39:32] blue_in,
  // [47:40] alpha_in, [59:48] target_x, [71:60] target_y
  input  logic [71:0] in_tdata,
  // [0] op
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] red_half, [31:16] green_half, [47:32] blue_half, [63:48] alpha_half
  output logic [63:0] out_tdata,
  // [0] out_of_range
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import nscr_pkg::*;

  localparam logic [COORD_W-1:0] CMASK = (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} :
                                         COORD_W'((1 << COORD_BITS) - 1);
  localparam int unsigned AW = (SOURCE_PIXELS > 1) ? $clog2(SOURCE_PIXELS) : 1;

  typedef struct packed {
    logic        req;
    logic        oor;
    logic [15:0] addr;
    logic [31:0] pix;
  } side_t;

  // ---------------------------------------------------------------- config
  logic [8:0]  src_w_r, src_h_r;
  logic [11:0] tgt_w_r, tgt_h_r;
  logic        crop_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= 9'd256;
      src_h_r <= 9'd256;
      tgt_w_r <= 12'd640;
      tgt_h_r <= 12'd480;
      crop_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SRC_W: src_w_r <= cfg_pwdata[8:0];
        REG_SRC_H: src_h_r <= cfg_pwdata[8:0];
        REG_TGT_W: tgt_w_r <= cfg_pwdata[11:0];
        REG_TGT_H: tgt_h_r <= cfg_pwdata[11:0];
        REG_CROP:  crop_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SRC_W: cfg_prdata = {23'd0, src_w_r};
      REG_SRC_H: cfg_prdata = {23'd0, src_h_r};
      REG_TGT_W: cfg_prdata = {20'd0, tgt_w_r};
      REG_TGT_H: cfg_prdata = {20'd0, tgt_h_r};
      REG_CROP:  cfg_prdata = {31'd0, crop_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  // saturate source size to 1..256
  logic [8:0]  w, h;
  logic [11:0] tw, th;
  logic [10:0] w3, h4;
  logic        crop_x, crop_y;

  assign w  = (src_w_r == 9'd0) ? 9'd1 : (src_w_r > 9'd256) ? 9'd256 : src_w_r;
  assign h  = (src_h_r == 9'd0) ? 9'd1 : (src_h_r > 9'd256) ? 9'd256 : src_h_r;
  assign tw = tgt_w_r & CMASK;
  assign th = tgt_h_r & CMASK;
  assign w3 = 11'(w) + 11'({w, 1'b0});
  assign h4 = {h, 2'b00};
  assign crop_x = crop_r & (w3 > h4);
  assign crop_y = crop_r & (w3 < h4);

  // ---------------------------------------------------------------- control
  logic [1:0] cnt_r;
  logic       en;
  logic       acc;

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;
  assign acc       = in_tvalid & in_tready;

  // ---------------------------------------------------------------- lanes
  logic [11:0] tx, ty;
  logic [DIV_STAGES-1:0] qx, qy;

  assign tx = in_tdata[59:48] & CMASK;
  assign ty = in_tdata[71:60] & CMASK;

  nscr_lane u_lane_x (
    .clk     (clk),
    .en      (en),
    .coord   (tx),
    .mul_a   (crop_x ? h4 : 11'(w)),
    .tsize   (tw),
    .off_mul (crop_x ? OFF_W'(w3 - h4) : '0),
    .den     (crop_x ? (DEN_W'({tw, 2'b00}) + DEN_W'({tw, 1'b0})) : DEN_W'({tw, 1'b0})),
    .quot    (qx)
  );

  nscr_lane u_lane_y (
    .clk     (clk),
    .en      (en),
    .coord   (ty),
    .mul_a   (crop_y ? w3 : 11'(h)),
    .tsize   (th),
    .off_mul (crop_y ? OFF_W'(h4 - w3) : '0),
    .den     (crop_y ? DEN_W'({th, 3'b000}) : DEN_W'({th, 1'b0})),
    .quot    (qy)
  );

  // side data travels beside the lanes
  logic [LANE_LAT-1:0] vld_r;
  side_t               side_r [LANE_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LANE_LAT-2:0], acc};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0].req  <= in_tuser;
      side_r[0].oor  <= (tx >= tw) | (ty >= th);
      side_r[0].addr <= in_tdata[15:0];
      side_r[0].pix  <= in_tdata[47:16];
      for (int i = 1; i < LANE_LAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  // ---------------------------------------------------------------- merge
  side_t      tail;
  logic [8:0] sx, sy;
  logic [8:0] wm1, hm1;
  logic [17:0] row_base;

  assign tail     = side_r[LANE_LAT-1];
  assign wm1      = w - 9'd1;
  assign hm1      = h - 9'd1;
  assign sx       = (qx > wm1) ? wm1 : qx;
  assign sy       = (qy > hm1) ? hm1 : qy;
  assign row_base = sy * w;

  logic        m1_vld_r, m1_req_r, m1_oor_r;
  logic [15:0] m1_addr_r;
  logic [31:0] m1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= vld_r[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_req_r  <= tail.req;
      m1_oor_r  <= tail.oor;
      m1_addr_r <= (tail.req == OP_REQUEST) ? 16'(row_base + 18'(sx)) : tail.addr;
      m1_pix_r  <= tail.pix;
    end
  end

  // loads write and requests read at the same stage, so order holds
  logic        in_store;
  logic [31:0] rdata;

  assign in_store = ({16'd0, m1_addr_r} < 32'(SOURCE_PIXELS));

  nscr_ram #(
    .WIDTH (32),
    .DEPTH (SOURCE_PIXELS)
  ) u_store (
    .clk   (clk),
    .en    (en & m1_vld_r),
    .we    ((m1_req_r == OP_LOAD) & in_store),
    .addr  (AW'(m1_addr_r)),
    .wdata (m1_pix_r),
    .rdata (rdata)
  );

  logic m2_vld_r, m2_req_r, m2_oor_r, m2_keep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_req_r  <= m1_req_r;
      m2_oor_r  <= m1_oor_r;
      m2_keep_r <= in_store & ~m1_oor_r;
    end
  end

  // four channel conversions side by side; zero byte maps to a zero half
  logic [31:0] pix_sel;
  logic [64:0] res;
  logic        push, pop;

  assign pix_sel = m2_keep_r ? rdata : 32'd0;
  assign res = {m2_oor_r, HALF_LUT[pix_sel[31:24]], HALF_LUT[pix_sel[23:16]],
                HALF_LUT[pix_sel[15:8]], HALF_LUT[pix_sel[7:0]]};
  assign push = en & m2_vld_r & (m2_req_r == OP_REQUEST);

  // ---------------------------------------------------------------- output buffer
  logic [64:0] ent0_r, ent1_r;

  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid & out_tready;
  assign out_tdata  = ent0_r[63:0];
  assign out_tuser  = ent0_r[64];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt_r == 2'd2) ent0_r <= ent1_r;
      else if (push)     ent0_r <= res;
    end else if (push) begin
      if (cnt_r == 2'd0) ent0_r <= res;
      else               ent1_r <= res;
    end
  end

endmodule

// ===== src/nscr_ram.sv =====
module nscr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
    end
  end

endmodule

// ===== src/nscr_lane.sv =====
module nscr_lane (
  input  logic                     clk,
  input  logic                     en,
  input  logic [nscr_pkg::COORD_W-1:0] coord,
  input  logic [nscr_pkg::MUL_W-1:0]   mul_a,
  input  logic [nscr_pkg::COORD_W-1:0] tsize,
  input  logic [nscr_pkg::OFF_W-1:0]   off_mul,
  input  logic [nscr_pkg::DEN_W-1:0]   den,
  output logic [nscr_pkg::DIV_STAGES-1:0] quot
);
  import nscr_pkg::*;

  // products
  logic [REM_W-1:0] prod_a_r;
  logic [REM_W-1:0] prod_b_r;
  logic [DEN_W-1:0] den_s1_r;

  // divider stages; index 0 is the summed numerator
  logic [REM_W-1:0]      rem_r  [DIV_STAGES+1];
  logic [DIV_STAGES-1:0] qacc_r [DIV_STAGES+1];
  logic [DEN_W-1:0]      den_r  [DIV_STAGES+1];

  logic [REM_W-1:0]      trial [DIV_STAGES];
  logic [DIV_STAGES-1:0] ge;

  logic [COORD_W:0] odd;
  assign odd = {coord, 1'b1};

  // one quotient bit per stage, most significant first
  always_comb begin
    for (int j = 0; j < DIV_STAGES; j++) begin
      trial[j] = REM_W'(den_r[j]) << (DIV_STAGES - 1 - j);
      ge[j]    = (rem_r[j] >= trial[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a_r  <= REM_W'(odd) * REM_W'(mul_a);
      prod_b_r  <= REM_W'(tsize) * REM_W'(off_mul);
      den_s1_r  <= den;
      rem_r[0]  <= prod_a_r + prod_b_r;
      qacc_r[0] <= '0;
      den_r[0]  <= den_s1_r;
      for (int j = 0; j < DIV_STAGES; j++) begin
        rem_r[j+1]  <= ge[j] ? (rem_r[j] - trial[j]) : rem_r[j];
        qacc_r[j+1] <= qacc_r[j] | (DIV_STAGES'(ge[j]) << (DIV_STAGES - 1 - j));
        den_r[j+1]  <= den_r[j];
      end
    end
  end

  assign quot = qacc_r[DIV_STAGES];

endmodule

// ===== src/nscr_checker.sv =====
module nscr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser,
  input logic        cfg_pready
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 64'd0)
    else $error("out of range result carries nonzero halves");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked while output buffer empty");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("config port not ready");

endmodule

bind nearest_scale_crop_rgba8_to_half nscr_checker u_nscr_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import nscr_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned STALL_LIMIT  = 20000;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic        oor;
  } half_pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // [15:0] pixel_addr, [23:16] red_in, [31:24] green_in, [39:32] blue_in,
  // [47:40] alpha_in, [59:48] target_x, [71:60] target_y
  logic [71:0] in_tdata;
  // [0] op
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  // [15:0] red_half, [31:16] green_half, [47:32] blue_half, [63:48] alpha_half
  logic [63:0] out_tdata;
  // [0] out_of_range
  logic        out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state: mirror of the registers and of the source frame
  logic [8:0]  src_w_reg;
  logic [8:0]  src_h_reg;
  logic [11:0] tgt_w_reg;
  logic [11:0] tgt_h_reg;
  logic        crop_reg;
  logic [31:0] frame_mem [int];
  half_pixel_t pending_pixels [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_cycles;
  int unsigned quiet_cycles;
  int unsigned error_count;

  nearest_scale_crop_rgba8_to_half u_top (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // half code of b/255: round to single, then round the mantissa half up
  function automatic logic [15:0] byte_half(input logic [7:0] b);
    longint unsigned k, num, q, r;
    k = 0;
    if (b == 0) return 16'h0000;
    while ((longint'(b) << k) < 255) k++;
    num = longint'(b) << (23 + k);
    q = num / 255;
    r = num % 255;
    if (2 * r > 255) q++;
    if (q >= 64'h1000000) begin
      q = q >> 1;
      if (k > 0) k--;
    end
    return 16'((((15 - k) << 10) + (((q & 64'h7fffff) + 64'h1000) >> 13)) & 64'hffff);
  endfunction

  function automatic longint unsigned clamp_src(input logic [8:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return longint'(v);
  endfunction

  // nearest-neighbour sample of one target pixel
  function automatic half_pixel_t sample_pixel(input logic [11:0] x, input logic [11:0] y);
    half_pixel_t res;
    longint unsigned w, h, tw, th, sx, sy, addr;
    logic [31:0] pix;
    res = '0;
    tw = tgt_w_reg;
    th = tgt_h_reg;
    if (x >= tw || y >= th) begin
      res.oor = 1'b1;
      return res;
    end
    w = clamp_src(src_w_reg);
    h = clamp_src(src_h_reg);
    sx = ((2 * x + 1) * w) / (2 * tw);
    sy = ((2 * y + 1) * h) / (2 * th);
    if (crop_reg) begin
      if (3 * w > 4 * h) sx = ((2 * x + 1) * 4 * h + tw * (3 * w - 4 * h)) / (6 * tw);
      else if (3 * w < 4 * h) sy = ((2 * y + 1) * 3 * w + th * (4 * h - 3 * w)) / (8 * th);
    end
    if (sx > w - 1) sx = w - 1;
    if (sy > h - 1) sy = h - 1;
    addr = sy * w + sx;
    pix = frame_mem.exists(int'(addr)) ? frame_mem[int'(addr)] : 32'h0;
    res.red   = byte_half(pix[7:0]);
    res.green = byte_half(pix[15:8]);
    res.blue  = byte_half(pix[23:16]);
    res.alpha = byte_half(pix[31:24]);
    return res;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SRC_W: src_w_reg = val[8:0];
      REG_SRC_H: src_h_reg = val[8:0];
      REG_TGT_W: tgt_w_reg = val[11:0];
      REG_TGT_H: tgt_h_reg = val[11:0];
      REG_CROP:  crop_reg  = val[0];
      default: ;
    endcase
    // leave the bus idle between transfers
    @(posedge clk);
  endtask

  task automatic set_geometry(input int sw, input int sh, input int tw, input int th,
                              input logic crop);
    write_reg(REG_SRC_W, sw);
    write_reg(REG_SRC_H, sh);
    write_reg(REG_TGT_W, tw);
    write_reg(REG_TGT_H, th);
    write_reg(REG_CROP, crop);
  endtask

  // send one item; predict on acceptance; valid stays high until a later send idles or wait_idle drops it
  task automatic send_item(input logic op, input logic [71:0] data);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    if (op == OP_LOAD) frame_mem[int'(data[15:0])] = data[47:16];
    else pending_pixels.push_back(sample_pixel(data[59:48], data[71:60]));
  endtask

  task automatic load_pixel(input int addr, input logic [31:0] rgba);
    logic [71:0] d;
    d = {24'($urandom), rgba, 16'(addr)};
    send_item(OP_LOAD, d);
  endtask

  task automatic request_pixel(input int x, input int y);
    logic [71:0] d;
    d = {12'(y), 12'(x), 48'({$urandom, $urandom})};
    send_item(OP_REQUEST, d);
  endtask

  // fill the whole used part of the frame so that no unwritten entry is read
  task automatic load_frame(input int sw, input int sh);
    for (int i = 0; i < sw * sh; i++) load_pixel(i, $urandom);
  endtask

  // hold until every expected result is in, then let the pipe empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_requests(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        request_pixel($urandom_range(4095), $urandom_range(4095));
      else
        request_pixel($urandom_range(tgt_w_reg - 1), $urandom_range(tgt_h_reg - 1));
    end
  endtask

  task automatic test_directed();
    set_geometry(4, 3, 8, 6, 1'b0);
    // extremes of the bytes, including all-zero and all-one pixels
    load_pixel(0, 32'h00000000);
    load_pixel(1, 32'hffffffff);
    load_pixel(2, 32'h807f0102);
    load_pixel(3, 32'h55aa33cc);
    for (int i = 4; i < 12; i++) load_pixel(i, $urandom);
    // load beyond the used frame; harmless
    load_pixel(65535, 32'hdeadbeef);
    request_pixel(0, 0);
    request_pixel(7, 5);
    request_pixel(2, 0);
    request_pixel(3, 1);
    // coordinate outside the target
    request_pixel(8, 0);
    request_pixel(0, 6);
    request_pixel(4095, 4095);
    wait_idle();
  endtask

  task automatic test_geometries();
    // crop wide, crop tall, crop exact 4:3, one-pixel source
    set_geometry(16, 6, 37, 11, 1'b1);  load_frame(16, 6);  random_requests(30);
    wait_idle();
    set_geometry(5, 20, 9, 50, 1'b1);   load_frame(5, 20);  random_requests(30);
    wait_idle();
    set_geometry(8, 6, 13, 7, 1'b1);    load_frame(8, 6);   random_requests(20);
    wait_idle();
    set_geometry(1, 1, 4095, 4095, 1'b0); load_pixel(0, $urandom); random_requests(30);
    wait_idle();
    // zero source reads as one, oversize saturates, zero target is all outside
    set_geometry(0, 0, 3, 3, 1'b0);     random_requests(10);
    wait_idle();
    set_geometry(511, 256, 1, 1, 1'b0);
    load_pixel(128 * 256 + 128, $urandom);
    request_pixel(0, 0);  // samples column 128 of row 128
    wait_idle();
    set_geometry(3, 3, 0, 0, 1'b0);     random_requests(10);
    wait_idle();
  endtask

  // a small frame loaded once and sampled under random geometries inside it
  task automatic test_full_frame();
    set_geometry(10, 8, 4095, 1, 1'b1);
    load_frame(10, 8);
    for (int i = 0; i < 4; i++) begin
      random_requests(30);
      wait_idle();
      set_geometry($urandom_range(1, 10), $urandom_range(1, 8),
                   $urandom_range(1, 4095), $urandom_range(1, 4095), $urandom_range(1));
    end
    random_requests(30);
    wait_idle();
  endtask

  task automatic test_pressure();
    // long receiver hold-off while the sender keeps going: the pipe must fill
    hold_off_cycles = 300;
    random_requests(80);
    wait_idle();
    send_idle_pct = 76;  random_requests(80);
    send_idle_pct = 0;   recv_stall_pct = 76;  random_requests(80);
    send_idle_pct = 21;  recv_stall_pct = 21;
    for (int i = 0; i < 60; i++) begin
      if ($urandom_range(3) == 0) load_pixel($urandom_range(65535), $urandom);
      else random_requests(1);
    end
    send_idle_pct = 0;   recv_stall_pct = 0;
    wait_idle();
  endtask

  // receiver: random stalls, a counted hold-off on request, and checking
  initial begin
    half_pixel_t want;
    half_pixel_t got;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      out_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tdata[63:48],
               out_tuser};
        if (pending_pixels.size() == 0) begin
          $error("unexpected result %h", got);
          error_count++;
        end else begin
          want = pending_pixels.pop_front();
          if (got.red !== want.red) begin
            $error("red_half exp %h got %h", want.red, got.red); error_count++;
          end
          if (got.green !== want.green) begin
            $error("green_half exp %h got %h", want.green, got.green); error_count++;
          end
          if (got.blue !== want.blue) begin
            $error("blue_half exp %h got %h", want.blue, got.blue); error_count++;
          end
          if (got.alpha !== want.alpha) begin
            $error("alpha_half exp %h got %h", want.alpha, got.alpha); error_count++;
          end
          if (got.oor !== want.oor) begin
            $error("out_of_range exp %b got %b", want.oor, got.oor); error_count++;
          end
        end
      end
    end
  end

  // watchdog: cycles with no item moving on either side
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        quiet_cycles = 0;
      else if (++quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;  in_tuser = 1'b0;  in_tdata = '0;
    cfg_psel = 1'b0;   cfg_penable = 1'b0;  cfg_pwrite = 1'b0;
    cfg_paddr = '0;    cfg_pwdata = '0;
    src_w_reg = 9'd256;  src_h_reg = 9'd256;
    tgt_w_reg = 12'd640; tgt_h_reg = 12'd480;  crop_reg = 1'b0;
    send_idle_pct = 0;   recv_stall_pct = 0;   hold_off_cycles = 0;
    error_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_geometries();
    test_full_frame();
    test_pressure();
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
